[rtl/core/aae_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package aae_pkg;

  localparam int MAX_LENGTH = 4096;
  // Position counter must hold MAX_LENGTH itself
  localparam int POS_W = $clog2(MAX_LENGTH + 1);

  localparam int START_W  = 12;
  localparam int LENGTH_W = 13;
  localparam int EXT_W    = (POS_W > LENGTH_W) ? POS_W : LENGTH_W;

  localparam logic [7:0] CH_ESC   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam logic signed [7:0] DEPTH_MAX = 8'sh7F;
  localparam logic signed [7:0] DEPTH_MIN = 8'sh80;

  typedef struct packed {
    logic              seeking_close;
    logic              in_quotes;
    logic              escape_pending;
    logic signed [7:0] comment_depth;
    logic [POS_W-1:0]  byte_position;
    logic [POS_W-1:0]  open_offset;
    logic [POS_W-1:0]  best_start;
    logic [POS_W-1:0]  best_length;
    logic              have_pair;
    logic              overflowed;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    seeking_close:  1'b0,
    in_quotes:      1'b0,
    escape_pending: 1'b0,
    comment_depth:  8'sh00,
    byte_position:  '0,
    open_offset:    '0,
    best_start:     '0,
    best_length:    '0,
    have_pair:      1'b0,
    overflowed:     1'b0
  };

  typedef struct packed {
    logic [START_W-1:0]  addr_start;
    logic [LENGTH_W-1:0] addr_length;
    logic                found_pair;
    logic                too_long;
  } scan_result_t;

endpackage

`default_nettype wire

[rtl/core/aae_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module aae_scan (
  input  wire aae_pkg::scan_state_t  cur,
  input  wire logic [7:0]            char_byte,
  input  wire logic                  is_last,
  output aae_pkg::scan_state_t       nxt,
  output aae_pkg::scan_result_t      result
);

  aae_pkg::scan_state_t            p;
  logic [aae_pkg::EXT_W-1:0]       start_ext;
  logic [aae_pkg::EXT_W-1:0]       length_ext;

  always_comb begin
    p = cur;
    if (cur.byte_position >= aae_pkg::POS_W'(aae_pkg::MAX_LENGTH)) begin
      // drop bytes past the limit, only flag them
      p.overflowed = 1'b1;
    end else begin
      p.byte_position = cur.byte_position + 1'b1;
      priority if (cur.escape_pending) begin
        p.escape_pending = 1'b0;
      end else if (char_byte == aae_pkg::CH_ESC) begin
        p.escape_pending = 1'b1;
      end else if (char_byte == aae_pkg::CH_QUOTE) begin
        p.in_quotes = !cur.in_quotes;
      end else if (!cur.in_quotes) begin
        priority if (char_byte == aae_pkg::CH_LPAR) begin
          if (cur.comment_depth != aae_pkg::DEPTH_MAX)
            p.comment_depth = cur.comment_depth + 8'sd1;
        end else if (char_byte == aae_pkg::CH_RPAR) begin
          if (cur.comment_depth != aae_pkg::DEPTH_MIN)
            p.comment_depth = cur.comment_depth - 8'sd1;
        end else if (cur.comment_depth == 8'sd0) begin
          priority if (!cur.seeking_close && char_byte == aae_pkg::CH_LT) begin
            p.open_offset    = cur.byte_position + 1'b1;
            p.seeking_close  = 1'b1;
            p.in_quotes      = 1'b0;
            p.escape_pending = 1'b0;
            p.comment_depth  = 8'sd0;
          end else if (cur.seeking_close && char_byte == aae_pkg::CH_GT) begin
            p.best_start     = cur.open_offset;
            p.best_length    = cur.byte_position - cur.open_offset;
            p.have_pair      = 1'b1;
            p.seeking_close  = 1'b0;
            p.in_quotes      = 1'b0;
            p.escape_pending = 1'b0;
            p.comment_depth  = 8'sd0;
          end else begin
            p.seeking_close = cur.seeking_close;
          end
        end else begin
          p.comment_depth = cur.comment_depth;
        end
      end else begin
        p.in_quotes = cur.in_quotes;
      end
    end
  end

  assign start_ext  = p.have_pair ? aae_pkg::EXT_W'(p.best_start) : '0;
  assign length_ext = p.have_pair ? aae_pkg::EXT_W'(p.best_length)
                                  : aae_pkg::EXT_W'(p.byte_position);

  assign result.addr_start  = start_ext[aae_pkg::START_W-1:0];
  assign result.addr_length = length_ext[aae_pkg::LENGTH_W-1:0];
  assign result.found_pair  = p.have_pair;
  assign result.too_long    = p.overflowed;

  // end of string: start over for the next one
  assign nxt = is_last ? aae_pkg::SCAN_RESET : p;

endmodule

`default_nettype wire

[rtl/core/angle_address_extractor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Angle address extractor: takes a mail address string one byte per transfer
// (tlast on the final byte) and, once per string, returns the offset and length
// of the contents of the last complete <...> pair, or offset 0 and the whole
// string length when no pair closed. Backslash escapes, double quotes and
// nested parentheses are honored; brackets count only outside quotes and at
// comment depth zero. Bytes beyond MAX_LENGTH are not parsed and raise too_long.
// Throughput is one byte per cycle while out_tready is high; out_tvalid rises
// when the scan update moves the final byte from the input register into the
// state and result registers, which waits while a held result is not taken.
module angle_address_extractor_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_byte
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [11:0] addr_start, [24:12] addr_length, rest 0
  output logic [1:0]       out_tuser   // [0] found_pair, [1] too_long
);

  aae_pkg::scan_state_t  state_r;
  aae_pkg::scan_state_t  state_nxt;
  aae_pkg::scan_result_t result;
  aae_pkg::scan_result_t out_result_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  logic       adv;

  // the scan stage moves only when the result slot can take a value
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  aae_scan u_scan (
    .cur       (state_r),
    .char_byte (s1_byte_r),
    .is_last   (s1_last_r),
    .nxt       (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= aae_pkg::SCAN_RESET;
    end else begin
      if (in_tready)
        s1_valid_r <= in_tvalid;
      if (adv)
        state_r <= state_nxt;
      if (adv && s1_last_r)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (adv && s1_last_r)
      out_result_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_result_r.addr_length, out_result_r.addr_start};
  assign out_tuser  = {out_result_r.too_long, out_result_r.found_pair};

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int IDLE_PCT       = 29;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  angle_address_extractor_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Scanner copy: tracks one string and yields the extracted span on its last byte
  logic         pair_open;
  logic         in_quote;
  logic         escaped;
  int           paren_depth;
  int unsigned  scan_pos;
  int unsigned  open_at;
  int unsigned  pair_start;
  int unsigned  pair_len;
  logic         pair_seen;
  logic         overrun;

  aae_pkg::scan_result_t pending_results[$];
  aae_pkg::scan_result_t want;
  logic [7:0]   addr_buf[$];

  logic         steady = 1'b0;
  int           mismatches = 0;
  int           strings_sent = 0;
  int           bytes_sent = 0;
  int           results_checked = 0;
  int           idle_cycles = 0;

  function automatic void clear_scanner();
    pair_open   = 1'b0;
    in_quote    = 1'b0;
    escaped     = 1'b0;
    paren_depth = 0;
    scan_pos    = 0;
    open_at     = 0;
    pair_start  = 0;
    pair_len    = 0;
    pair_seen   = 1'b0;
    overrun     = 1'b0;
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic last);
    aae_pkg::scan_result_t res;
    if (scan_pos >= aae_pkg::MAX_LENGTH) begin
      overrun = 1'b1;
    end else begin
      if (escaped) begin
        escaped = 1'b0;
      end else if (c == aae_pkg::CH_ESC) begin
        escaped = 1'b1;
      end else if (c == aae_pkg::CH_QUOTE) begin
        in_quote = !in_quote;
      end else if (!in_quote) begin
        if (c == aae_pkg::CH_LPAR) begin
          if (paren_depth < int'(aae_pkg::DEPTH_MAX)) paren_depth++;
        end else if (c == aae_pkg::CH_RPAR) begin
          if (paren_depth > int'(aae_pkg::DEPTH_MIN)) paren_depth--;
        end else if (paren_depth == 0) begin
          if (!pair_open && c == aae_pkg::CH_LT) begin
            open_at     = scan_pos + 1;
            pair_open   = 1'b1;
            in_quote    = 1'b0;
            escaped     = 1'b0;
            paren_depth = 0;
          end else if (pair_open && c == aae_pkg::CH_GT) begin
            pair_start  = open_at;
            pair_len    = scan_pos - open_at;
            pair_seen   = 1'b1;
            pair_open   = 1'b0;
            in_quote    = 1'b0;
            escaped     = 1'b0;
            paren_depth = 0;
          end
        end
      end
      scan_pos++;
    end
    if (last) begin
      res.addr_start  = pair_seen ? pair_start[aae_pkg::START_W-1:0] : '0;
      res.addr_length = pair_seen ? pair_len[aae_pkg::LENGTH_W-1:0]
                                  : scan_pos[aae_pkg::LENGTH_W-1:0];
      res.found_pair  = pair_seen;
      res.too_long    = overrun;
      pending_results.push_back(res);
      clear_scanner();
    end
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_byte(c, last);
    bytes_sent++;
  endtask

  task automatic send_addr();
    for (int i = 0; i < addr_buf.size(); i++)
      send_byte(addr_buf[i], i == addr_buf.size() - 1);
    strings_sent++;
    addr_buf.delete();
  endtask

  // Lower valid and hold until the block has returned every result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) addr_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 5))
      0:       return aae_pkg::CH_ESC;
      1:       return aae_pkg::CH_QUOTE;
      2:       return aae_pkg::CH_LPAR;
      3:       return aae_pkg::CH_RPAR;
      4:       return aae_pkg::CH_LT;
      default: return aae_pkg::CH_GT;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(0, 99) < 80) return pick_letter();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_text(int max_len);
    int n;
    n = $urandom_range(0, max_len);
    repeat (n) addr_buf.push_back(pick_text_byte());
  endfunction

  // Mostly well-formed pieces (pairs, quotes, comments, escapes) plus loose noise
  function automatic void build_address();
    int tokens;
    tokens = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1: push_text(6);
        2, 3, 4: begin
          addr_buf.push_back(aae_pkg::CH_LT);
          push_text(8);
          addr_buf.push_back(aae_pkg::CH_GT);
        end
        5: begin
          addr_buf.push_back(aae_pkg::CH_QUOTE);
          push_text(4);
          if ($urandom_range(0, 1)) addr_buf.push_back(pick_special());
          push_text(3);
          if ($urandom_range(0, 4) != 0) addr_buf.push_back(aae_pkg::CH_QUOTE);
        end
        6: begin
          addr_buf.push_back(aae_pkg::CH_LPAR);
          push_text(4);
          if ($urandom_range(0, 2) == 0) begin
            addr_buf.push_back(aae_pkg::CH_LPAR);
            push_text(3);
            addr_buf.push_back(aae_pkg::CH_RPAR);
          end
          if ($urandom_range(0, 4) != 0) addr_buf.push_back(aae_pkg::CH_RPAR);
        end
        7: begin
          addr_buf.push_back(aae_pkg::CH_ESC);
          addr_buf.push_back(pick_special());
        end
        8: addr_buf.push_back(pick_special());
        default: addr_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (addr_buf.size() == 0) addr_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic test_directed_cases();
    // single zero byte: whole string of one
    addr_buf.push_back(8'h00);
    send_addr();
    // all-ones byte ahead of an empty pair
    addr_buf.push_back(8'hFF);
    push_str("<>");
    send_addr();
    // bracket inside quotes is skipped
    push_str("\"<\"<a>");
    send_addr();
    // bracket inside a comment is skipped
    push_str("(<)<a>");
    send_addr();
    // close paren at depth zero goes negative and blocks the pair
    push_str(")<a>");
    send_addr();
    // escape on the final byte, pair left unclosed
    push_str("<a\\");
    send_addr();
    // escaped bracket is skipped, then the pair <b> is found
    push_str("\\<a><b>");
    send_addr();
    drain_results();
  endtask

  task automatic test_comment_saturation();
    repeat (130) addr_buf.push_back(aae_pkg::CH_LPAR);
    repeat (127) addr_buf.push_back(aae_pkg::CH_RPAR);
    push_str("<a>");
    send_addr();
    repeat (130) addr_buf.push_back(aae_pkg::CH_RPAR);
    repeat (128) addr_buf.push_back(aae_pkg::CH_LPAR);
    push_str("<bc>");
    send_addr();
    drain_results();
  endtask

  task automatic test_random_addresses(int byte_budget);
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < byte_budget) begin
      build_address();
      send_addr();
      if ($urandom_range(0, 29) == 0) drain_results();
    end
    drain_results();
  endtask

  task automatic test_back_to_back(int byte_budget);
    int start_bytes;
    start_bytes = bytes_sent;
    steady = 1'b1;
    while (bytes_sent - start_bytes < byte_budget) begin
      build_address();
      send_addr();
    end
    steady = 1'b0;
    drain_results();
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned exp);
    if (got != exp) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual tdata=%h tuser=%b",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("addr_start", out_tdata[11:0], want.addr_start);
        check_field("addr_length", out_tdata[24:12], want.addr_length);
        check_field("tdata pad", out_tdata[31:25], 0);
        check_field("found_pair", out_tuser[0], want.found_pair);
        check_field("too_long", out_tuser[1], want.too_long);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clear_scanner();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_comment_saturation();
    test_random_addresses(350);
    test_back_to_back(200);
    test_random_addresses(350);

    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatches++;
    end
    $display("Ran %0d strings (%0d bytes) and checked %0d results, with quotes, comments,",
             strings_sent, bytes_sent, results_checked);
    $display("escapes, comment depth saturation and back-to-back traffic.");
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
